// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: rtl/core/arfh_pkg.sv
package arfh_pkg;

  // sizing
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned BINS        = 100;
  localparam int unsigned ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int unsigned FILL_W      = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BIN_W       = $clog2(BINS);
  localparam int unsigned COUNT_W     = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // range widening divides the span by this
  localparam int unsigned EPS_DIVISOR = 100;

  // reset value of the minimum bin width register
  localparam logic [15:0] MIN_WIDTH_RST = 16'd66;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_DONE     = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_HIST  = 3'd4
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [31:0] sample;
    logic [6:0]         bin_index;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic signed [31:0]   bin_low_edge;
    logic [COUNT_W-1:0]   bin_count;
    logic signed [31:0]   range_low;
    logic signed [31:0]   range_high;
  } out_t;

  // clip a wide signed value into signed q16.16
  function automatic logic signed [31:0] sat_q16(input logic signed [40:0] v);
    logic signed [40:0] hi_lim;
    logic signed [40:0] lo_lim;
    hi_lim = 41'sd2147483647;
    lo_lim = -41'sd2147483648;
    if (v > hi_lim) begin
      sat_q16 = 32'sh7fffffff;
    end else if (v < lo_lim) begin
      sat_q16 = 32'sh80000000;
    end else begin
      sat_q16 = v[31:0];
    end
  endfunction

endpackage

// File: rtl/core/auto_range_field_histogram.sv
// Auto-ranged histogram of signed Q16.16 samples. Load requests write the sample
// store and track min/max as they are accepted, so loads stream at one per cycle
// while the output is free or taken. Clear is answered straight from idle, as is
// a read when no histogram exists; other reads go through multiply, edge and high
// edge states. A compute request widens the range by one hundredth of the span,
// derives the bin width and then walks the store one sample at a time; every
// division goes through one shared 33-step restoring divider, which a sample at
// or below the low end skips. Bin counts carry per-bin valid flags, so no clearing
// pass is needed. The input is not ready while a compute or a read is running.
`include "assert_macros.svh"

module auto_range_field_histogram (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  arfh_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output arfh_pkg::out_t     out_data_o
);

  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_EPS_DIV  = 12'b0000_0000_0010,
    S_ENDS     = 12'b0000_0000_0100,
    S_WID_DIV  = 12'b0000_0000_1000,
    S_PASS_RD  = 12'b0000_0001_0000,
    S_PASS_DAT = 12'b0000_0010_0000,
    S_PASS_DIV = 12'b0000_0100_0000,
    S_PASS_CRD = 12'b0000_1000_0000,
    S_PASS_CWR = 12'b0001_0000_0000,
    S_RD_MUL   = 12'b0010_0000_0000,
    S_RD_EDGE  = 12'b0100_0000_0000,
    S_RD_HI    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [arfh_pkg::FILL_W-1:0]  samples_loaded_q, samples_loaded_d;
  logic signed [31:0]           run_min_q, run_min_d;
  logic signed [31:0]           run_max_q, run_max_d;
  logic signed [31:0]           hist_low_q, hist_low_d;
  logic [31:0]                  hist_width_q, hist_width_d;
  logic                         hist_ready_q, hist_ready_d;
  logic [15:0]                  min_bin_width_q, min_bin_width_d;
  logic [arfh_pkg::BINS-1:0]    cnt_vld_q, cnt_vld_d;
  logic signed [31:0]           wlo_q, wlo_d;
  logic signed [31:0]           whi_q, whi_d;
  logic [31:0]                  wwidth_q, wwidth_d;
  logic [arfh_pkg::FILL_W-1:0]  pass_idx_q, pass_idx_d;
  logic [arfh_pkg::BIN_W-1:0]   bin_q, bin_d;
  logic [6:0]                   rd_idx_q, rd_idx_d;
  logic signed [31:0]           edge_q, edge_d;
  logic [arfh_pkg::COUNT_W-1:0] rcount_q, rcount_d;
  logic                         out_valid_q, out_valid_d;
  arfh_pkg::out_t               out_data_q, out_data_d;

  // shared divider
  logic                         div_start;
  logic [32:0]                  div_dvd;
  logic [31:0]                  div_dsr;
  logic                         div_busy_q;
  logic                         div_fin_q;
  logic [DCNT_W-1:0]            div_cnt_q;
  logic [31:0]                  div_rem_q;
  logic [32:0]                  div_quo_q;
  logic [31:0]                  div_den_q;
  logic [32:0]                  div_shl;
  logic                         div_ge;
  logic [32:0]                  div_sub;

  // multiplier for bin edges
  logic [7:0]                   mul_b;
  logic [39:0]                  prod_q;

  // memories
  logic signed [31:0]           store_mem [arfh_pkg::MAX_SAMPLES];
  logic signed [31:0]           store_rdata_q;
  logic                         store_we;
  logic [arfh_pkg::COUNT_W-1:0] cnt_mem [arfh_pkg::BINS];
  logic [arfh_pkg::COUNT_W-1:0] cnt_rdata_q;
  logic [arfh_pkg::BIN_W-1:0]   cnt_raddr;
  logic                         cnt_we;
  logic [arfh_pkg::COUNT_W-1:0] cnt_wdata;

  // scratch arithmetic
  logic                         accept;
  logic                         out_load;
  arfh_pkg::out_t               res;
  logic signed [32:0]           span;
  logic signed [33:0]           lo_wide;
  logic signed [33:0]           hi_wide;
  logic signed [33:0]           diff;
  logic signed [40:0]           edge_sum;
  logic                         rd_in_range;
  logic [arfh_pkg::BIN_W-1:0]   rd_cidx;
  logic [arfh_pkg::COUNT_W-1:0] old_count;

  // check helpers
  logic                         fill_over;
  logic                         done_shown;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // read index helpers
  assign rd_in_range = 32'(rd_idx_q) < arfh_pkg::BINS;
  assign rd_cidx     = rd_in_range ? arfh_pkg::BIN_W'(rd_idx_q) : '0;
  assign cnt_raddr   = (state_q == S_PASS_CRD) ? bin_q : rd_cidx;

  // edge adder shared by the read states
  assign edge_sum = $signed({{9{hist_low_q[31]}}, hist_low_q}) + $signed({1'b0, prod_q});

  // one restoring step of the divider
  assign div_shl = {div_rem_q, div_quo_q[32]};
  assign div_ge  = div_shl >= {1'b0, div_den_q};
  assign div_sub = div_shl - {1'b0, div_den_q};

  // sequencer and next-state logic
  always_comb begin
    state_d          = state_q;
    samples_loaded_d = samples_loaded_q;
    run_min_d        = run_min_q;
    run_max_d        = run_max_q;
    hist_low_d       = hist_low_q;
    hist_width_d     = hist_width_q;
    hist_ready_d     = hist_ready_q;
    min_bin_width_d  = min_bin_width_q;
    cnt_vld_d        = cnt_vld_q;
    wlo_d            = wlo_q;
    whi_d            = whi_q;
    wwidth_d         = wwidth_q;
    pass_idx_d       = pass_idx_q;
    bin_d            = bin_q;
    rd_idx_d         = rd_idx_q;
    edge_d           = edge_q;
    rcount_d         = rcount_q;
    div_start        = 1'b0;
    div_dvd          = '0;
    div_dsr          = '0;
    store_we         = 1'b0;
    cnt_we           = 1'b0;
    cnt_wdata        = '0;
    mul_b            = 8'(arfh_pkg::BINS);
    out_load         = 1'b0;
    res              = '0;
    span             = $signed({run_max_q[31], run_max_q}) - $signed({run_min_q[31], run_min_q});
    lo_wide          = $signed({{2{run_min_q[31]}}, run_min_q}) - $signed({1'b0, div_quo_q});
    hi_wide          = $signed({{2{run_max_q[31]}}, run_max_q}) + $signed({1'b0, div_quo_q});
    diff             = $signed({{2{store_rdata_q[31]}}, store_rdata_q})
                     - $signed({{2{wlo_q[31]}}, wlo_q});
    old_count        = cnt_vld_q[bin_q] ? cnt_rdata_q : '0;

    if (cfg_valid_i) begin
      min_bin_width_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.opcode)
            arfh_pkg::OP_LOAD: begin
              out_load = 1'b1;
              if (samples_loaded_q >= arfh_pkg::FILL_W'(arfh_pkg::MAX_SAMPLES)) begin
                res.status = arfh_pkg::ST_FULL;
              end else begin
                res.status       = arfh_pkg::ST_ACCEPTED;
                store_we         = 1'b1;
                samples_loaded_d = samples_loaded_q + 1'b1;
                if (samples_loaded_q == '0) begin
                  run_min_d = in_data_i.sample;
                  run_max_d = in_data_i.sample;
                end else begin
                  if (in_data_i.sample > run_max_q) run_max_d = in_data_i.sample;
                  if (in_data_i.sample < run_min_q) run_min_d = in_data_i.sample;
                end
              end
            end
            arfh_pkg::OP_COMPUTE: begin
              div_start = 1'b1;
              div_dvd   = span;
              div_dsr   = 32'(arfh_pkg::EPS_DIVISOR);
              state_d   = S_EPS_DIV;
            end
            arfh_pkg::OP_READ: begin
              if (!hist_ready_q) begin
                out_load   = 1'b1;
                res.status = arfh_pkg::ST_NO_HIST;
              end else begin
                rd_idx_d = in_data_i.bin_index;
                state_d  = S_RD_MUL;
              end
            end
            arfh_pkg::OP_CLEAR: begin
              out_load         = 1'b1;
              res.status       = arfh_pkg::ST_ACCEPTED;
              samples_loaded_d = '0;
              run_min_d        = '0;
              run_max_d        = '0;
              cnt_vld_d        = '0;
              hist_low_d       = '0;
              hist_width_d     = '0;
              hist_ready_d     = 1'b0;
            end
          endcase
        end
      end

      // widened ends, saturated
      S_EPS_DIV: begin
        if (div_fin_q) begin
          wlo_d   = arfh_pkg::sat_q16(41'(lo_wide));
          whi_d   = arfh_pkg::sat_q16(41'(hi_wide));
          state_d = S_ENDS;
        end
      end

      S_ENDS: begin
        div_start = 1'b1;
        div_dvd   = 33'($signed({whi_q[31], whi_q}) - $signed({wlo_q[31], wlo_q}));
        div_dsr   = 32'(arfh_pkg::BINS);
        state_d   = S_WID_DIV;
      end

      // width check, refuse or start the pass
      S_WID_DIV: begin
        if (div_fin_q) begin
          wwidth_d = div_quo_q[31:0];
          if (div_quo_q == '0 || div_quo_q < {17'd0, min_bin_width_q}) begin
            out_load         = 1'b1;
            res.status       = arfh_pkg::ST_REFUSED;
            res.range_low    = wlo_q;
            res.range_high   = whi_q;
            state_d          = S_IDLE;
          end else begin
            cnt_vld_d  = '0;
            pass_idx_d = '0;
            state_d    = S_PASS_RD;
          end
        end
      end

      S_PASS_RD: begin
        if (pass_idx_q == samples_loaded_q) begin
          hist_low_d     = wlo_q;
          hist_width_d   = wwidth_q;
          hist_ready_d   = 1'b1;
          out_load       = 1'b1;
          res.status     = arfh_pkg::ST_DONE;
          res.range_low  = wlo_q;
          res.range_high = whi_q;
          state_d        = S_IDLE;
        end else begin
          state_d = S_PASS_DAT;
        end
      end

      // offset from the low end, bin 0 if not positive, else divide by the width
      S_PASS_DAT: begin
        if (diff[33] || diff == '0) begin
          bin_d   = '0;
          state_d = S_PASS_CRD;
        end else begin
          div_start = 1'b1;
          div_dvd   = diff[32:0];
          div_dsr   = wwidth_q;
          state_d   = S_PASS_DIV;
        end
      end

      S_PASS_DIV: begin
        if (div_fin_q) begin
          if (div_quo_q > 33'(arfh_pkg::BINS - 1)) begin
            bin_d = arfh_pkg::BIN_W'(arfh_pkg::BINS - 1);
          end else begin
            bin_d = div_quo_q[arfh_pkg::BIN_W-1:0];
          end
          state_d = S_PASS_CRD;
        end
      end

      S_PASS_CRD: begin
        state_d = S_PASS_CWR;
      end

      // saturating count update
      S_PASS_CWR: begin
        cnt_we           = 1'b1;
        cnt_wdata        = (old_count == arfh_pkg::COUNT_MAX) ? old_count : old_count + 1'b1;
        cnt_vld_d[bin_q] = 1'b1;
        pass_idx_d       = pass_idx_q + 1'b1;
        state_d          = S_PASS_RD;
      end

      S_RD_MUL: begin
        mul_b   = {1'b0, rd_idx_q};
        state_d = S_RD_EDGE;
      end

      S_RD_EDGE: begin
        edge_d   = arfh_pkg::sat_q16(edge_sum);
        rcount_d = (rd_in_range && cnt_vld_q[rd_cidx]) ? cnt_rdata_q : '0;
        state_d  = S_RD_HI;
      end

      S_RD_HI: begin
        out_load         = 1'b1;
        res.status       = arfh_pkg::ST_ACCEPTED;
        res.bin_low_edge = edge_q;
        res.bin_count    = rcount_q;
        res.range_low    = hist_low_q;
        res.range_high   = arfh_pkg::sat_q16(edge_sum);
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // output register
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      samples_loaded_q <= '0;
      run_min_q        <= '0;
      run_max_q        <= '0;
      hist_low_q       <= '0;
      hist_width_q     <= '0;
      hist_ready_q     <= 1'b0;
      min_bin_width_q  <= arfh_pkg::MIN_WIDTH_RST;
      cnt_vld_q        <= '0;
      pass_idx_q       <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      samples_loaded_q <= samples_loaded_d;
      run_min_q        <= run_min_d;
      run_max_q        <= run_max_d;
      hist_low_q       <= hist_low_d;
      hist_width_q     <= hist_width_d;
      hist_ready_q     <= hist_ready_d;
      min_bin_width_q  <= min_bin_width_d;
      cnt_vld_q        <= cnt_vld_d;
      pass_idx_q       <= pass_idx_d;
      out_valid_q      <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wlo_q      <= wlo_d;
    whi_q      <= whi_d;
    wwidth_q   <= wwidth_d;
    bin_q      <= bin_d;
    rd_idx_q   <= rd_idx_d;
    edge_q     <= edge_d;
    rcount_q   <= rcount_d;
    out_data_q <= out_data_d;
    prod_q     <= hist_width_q * mul_b;
  end

  // divider control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_fin_q  <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
      div_fin_q  <= 1'b0;
      div_cnt_q  <= DCNT_W'(DIV_STEPS - 1);
    end else if (div_busy_q) begin
      if (div_cnt_q == '0) begin
        div_busy_q <= 1'b0;
        div_fin_q  <= 1'b1;
      end else begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end else begin
      div_fin_q <= 1'b0;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= div_dvd;
      div_den_q <= div_dsr;
    end else if (div_busy_q) begin
      div_rem_q <= div_ge ? div_sub[31:0] : div_shl[31:0];
      div_quo_q <= {div_quo_q[31:0], div_ge};
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[samples_loaded_q[arfh_pkg::ADDR_W-1:0]] <= in_data_i.sample;
    end
    store_rdata_q <= store_mem[pass_idx_q[arfh_pkg::ADDR_W-1:0]];
  end

  // bin count store
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[bin_q] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  // checks
  assign fill_over  = samples_loaded_q > arfh_pkg::FILL_W'(arfh_pkg::MAX_SAMPLES);
  assign done_shown = out_valid_q && (out_data_q.status == arfh_pkg::ST_DONE);

  `ASSERT_HOLDS(a_rdy_idle, clk_i, rst_ni, in_ready_o |-> (state_q == S_IDLE), "ready while busy")
  `ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_over, "fill count past store depth")
  `ASSERT_HOLDS(a_done_out, clk_i, rst_ni, $rose(hist_ready_q) |-> done_shown, "no done result")
  `ASSERT_HOLDS(a_div_fin, clk_i, rst_ni, div_fin_q |-> $past(div_busy_q), "divider not run")

endmodule
